[rtl/sfr_pkg.sv]
// Package: shared constants, beat types and control structs for the find/replace block.
package sfr_pkg;

    // Longest needle and substitute
    localparam int MAX_NEEDLE = 8;
    localparam int MAX_SUB    = 8;

    // One cell per byte of the working run (held bytes plus the new byte)
    localparam int CELLS  = MAX_NEEDLE;
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int HOLD_W = $clog2(CELLS);
    localparam int LEN_W  = 4;
    localparam int CFG_W  = 64;
    localparam int IDX_W  = 2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_NEEDLE_BYTES = 2'd0;
    localparam logic [IDX_W-1:0] REG_NEEDLE_LEN   = 2'd1;
    localparam logic [IDX_W-1:0] REG_SUB_BYTES    = 2'd2;
    localparam logic [IDX_W-1:0] REG_SUB_LEN      = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_final;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       string_end;
        logic       run_last;
    } out_beat_t;

    // Commands broadcast to every cell of the chain
    typedef struct packed {
        logic load_sub;
        logic shift;
    } cell_ctrl_t;

    // Outcome of the prefix search over the run
    typedef struct packed {
        logic             full;
        logic [CNT_W-1:0] start;
    } match_t;

endpackage

[rtl/sfr_cell.sv]
// Cell: one byte of the working run, compared against every needle byte.
module sfr_cell
    import sfr_pkg::*;
(
    input  logic                   aclk,
    input  cell_ctrl_t             ctrl,
    input  logic                   wr_in,
    input  logic [7:0]             in_byte,
    input  logic [7:0]             sub_byte,
    input  logic [7:0]             next_byte,
    input  logic [CFG_W-1:0]       needle,
    output logic [7:0]             cell_byte,
    output logic [CELLS-1:0]       eq
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // Pick the next content: substitute load, shift from the neighbor, or new input byte
    always_comb begin
        byte_next = byte_reg;
        priority if (ctrl.load_sub) begin
            byte_next = sub_byte;
        end else if (ctrl.shift) begin
            byte_next = next_byte;
        end else if (wr_in) begin
            byte_next = in_byte;
        end else begin
            byte_next = byte_reg;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    // Compare against each needle position
    always_comb begin
        for (int k = 0; k < CELLS; k++) begin
            eq[k] = (byte_reg == needle[8*k +: 8]);
        end
    end

    assign cell_byte = byte_reg;

endmodule

[rtl/sfr_match.sv]
// Prefix search: full-needle test and leftmost start of a surviving needle prefix.
module sfr_match
    import sfr_pkg::*;
(
    input  logic [CELLS-1:0] eq [CELLS],
    input  logic [CNT_W-1:0] run_len,
    input  logic [CNT_W-1:0] needle_len,
    output match_t           result
);

    logic [CELLS-1:0] ok;

    // Test every start: remaining run shorter than the needle and equal to its prefix
    always_comb begin
        for (int s = 0; s < CELLS; s++) begin
            ok[s] = (CNT_W'(s) < run_len) &&
                    ((run_len - CNT_W'(s)) < needle_len);
            for (int i = 0; i < CELLS - s; i++) begin
                if (CNT_W'(i) < (run_len - CNT_W'(s))) begin
                    ok[s] = ok[s] & eq[s + i][i];
                end
            end
        end
    end

    // Take the leftmost passing start; an empty remainder always passes
    always_comb begin
        result.start = run_len;
        for (int s = CELLS - 1; s >= 0; s--) begin
            if (ok[s]) begin
                result.start = CNT_W'(s);
            end
        end
    end

    // Whole run equals the whole needle
    always_comb begin
        result.full = (run_len == needle_len);
        for (int i = 0; i < CELLS; i++) begin
            if (CNT_W'(i) < run_len) begin
                result.full = result.full & eq[i][i];
            end
        end
    end

endmodule

[rtl/stream_find_replace.sv]
// Top level: streaming find/replace over a chain of byte cells.
//
// Takes a string one byte per beat and returns it with every leftmost,
// non-overlapping occurrence of the needle (1..8 bytes) replaced by the
// substitute (0..8 bytes). Up to needle length minus one bytes that may still
// begin a match are held back; the beat flagged in_final flushes them, and a
// final beat that yields no byte returns one empty end marker (has_byte 0).
// An input beat is taken while idle and evaluated in the next cycle; its results
// then leave one per cycle from the front of the cell chain while the output is
// not stalled, and no new beat is taken until the last result has been issued.
// Configuration writes take effect at once and belong to idle periods.
module stream_find_replace
    import sfr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_beat_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_beat_t        m_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CFG_W-1:0]  needle_reg;
    logic [LEN_W-1:0]  needle_len_reg;
    logic [CFG_W-1:0]  sub_reg;
    logic [LEN_W-1:0]  sub_len_reg;
    logic [HOLD_W-1:0] held_reg, held_next;
    logic [CNT_W-1:0]  run_len_reg, run_len_next;
    logic              final_reg, final_next;
    logic [CNT_W-1:0]  emit_reg, emit_next;
    logic              mark_reg, mark_next;
    logic              m_valid_reg;
    out_beat_t         m_data_reg;

    logic [CNT_W-1:0]  nl_eff;
    logic [CNT_W-1:0]  sl_eff;
    logic              in_fire;
    logic              out_free;
    logic              emit_fire;
    logic              last_beat;
    cell_ctrl_t        ctrl;
    match_t            match;
    logic [CNT_W-1:0]  eval_emit;
    logic [CNT_W-1:0]  eval_keep;
    logic [7:0]        cell_bytes [CELLS];
    logic [CELLS-1:0]  eq [CELLS];

    // Clamp the lengths into their legal ranges
    always_comb begin
        if (needle_len_reg == '0) begin
            nl_eff = CNT_W'(1);
        end else if (needle_len_reg > LEN_W'(MAX_NEEDLE)) begin
            nl_eff = CNT_W'(MAX_NEEDLE);
        end else begin
            nl_eff = CNT_W'(needle_len_reg);
        end
        if (sub_len_reg > LEN_W'(MAX_SUB)) begin
            sl_eff = CNT_W'(MAX_SUB);
        end else begin
            sl_eff = CNT_W'(sub_len_reg);
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needle_reg     <= '0;
            needle_len_reg <= LEN_W'(1);
            sub_reg        <= '0;
            sub_len_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_NEEDLE_BYTES: needle_reg     <= cfg_data;
                REG_NEEDLE_LEN:   needle_len_reg <= cfg_data[LEN_W-1:0];
                REG_SUB_BYTES:    sub_reg        <= cfg_data;
                REG_SUB_LEN:      sub_len_reg    <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_fire = (state_reg == ST_EMIT) && out_free;
    assign last_beat = mark_reg || (emit_reg == CNT_W'(1));

    // Plan the results of the evaluated run
    always_comb begin
        if (match.full) begin
            eval_emit = sl_eff;
            eval_keep = '0;
        end else if (final_reg) begin
            eval_emit = run_len_reg;
            eval_keep = '0;
        end else begin
            eval_emit = match.start;
            eval_keep = run_len_reg - match.start;
        end
    end

    // Chain commands
    always_comb begin
        ctrl.load_sub = (state_reg == ST_EVAL) && match.full;
        ctrl.shift    = emit_fire && !mark_reg;
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        held_next    = held_reg;
        run_len_next = run_len_reg;
        final_next   = final_reg;
        emit_next    = emit_reg;
        mark_next    = mark_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    run_len_next = CNT_W'(held_reg) + CNT_W'(1);
                    final_next   = s_data.in_final;
                    state_next   = ST_EVAL;
                end
            end
            ST_EVAL: begin
                held_next = eval_keep[HOLD_W-1:0];
                emit_next = eval_emit;
                mark_next = final_reg && (eval_emit == '0);
                if ((eval_emit == '0) && !final_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    emit_next = emit_reg - CNT_W'(!mark_reg);
                    if (last_beat) begin
                        mark_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            held_reg    <= '0;
            run_len_reg <= '0;
            final_reg   <= 1'b0;
            emit_reg    <= '0;
            mark_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            run_len_reg <= run_len_next;
            final_reg   <= final_next;
            emit_reg    <= emit_next;
            mark_reg    <= mark_next;
        end
    end

    // Output register: hold while stalled, load the chain front (or the end marker) on each emit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            m_data_reg.out_byte   <= mark_reg ? 8'd0 : cell_bytes[0];
            m_data_reg.has_byte   <= !mark_reg;
            m_data_reg.string_end <= last_beat && final_reg;
            m_data_reg.run_last   <= last_beat;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Row of byte cells, front at index zero, shifting toward the front
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        logic [7:0] next_byte;
        logic [7:0] sub_byte;

        if (g == CELLS - 1) begin : g_tail
            assign next_byte = 8'd0;
        end else begin : g_body
            assign next_byte = cell_bytes[g + 1];
        end

        if (g < MAX_SUB) begin : g_sub
            assign sub_byte = sub_reg[8*g +: 8];
        end else begin : g_nosub
            assign sub_byte = 8'd0;
        end

        sfr_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .wr_in     (in_fire && (CNT_W'(held_reg) == CNT_W'(g))),
            .in_byte   (s_data.in_byte),
            .sub_byte  (sub_byte),
            .next_byte (next_byte),
            .needle    (needle_reg),
            .cell_byte (cell_bytes[g]),
            .eq        (eq[g])
        );
    end

    sfr_match u_match (
        .eq         (eq),
        .run_len    (run_len_reg),
        .needle_len (nl_eff),
        .result     (match)
    );

endmodule

[rtl/sfr_checker.sv]
// Checker: port-level properties of the find/replace block, bound to the top level.
module sfr_checker
    import sfr_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             cfg_wr_en,
    input logic [IDX_W-1:0] cfg_index,
    input logic [CFG_W-1:0] cfg_data,
    input logic             s_valid,
    input logic             s_ready,
    input in_beat_t         s_data,
    input logic             m_valid,
    input logic             m_ready,
    input out_beat_t        m_data
);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // One input item at a time: the block is busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again before evaluation");

    // End marker closes both the run and the string, with a zero byte
    a_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.has_byte |->
            m_data.string_end && m_data.run_last && (m_data.out_byte == 8'd0))
        else $error("malformed end marker");

    // String end is always the last result of its run
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.string_end |-> m_data.run_last)
        else $error("string end not on last result");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);

[verif/stream_find_replace_test.sv]
`timescale 1ns / 1ps
// Testbench: directed and random find/replace streams checked beat by beat against a predictor.
module stream_find_replace_test;
    import sfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int PHASE_ITEMS    = 64;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             s_valid;
    logic             s_ready;
    in_beat_t         s_data;
    logic             m_valid;
    logic             m_ready = 1'b0;
    out_beat_t        m_data;

    // Shadow copy of the registers and of the held bytes
    logic [63:0] pat_bytes;
    logic [3:0]  pat_len;
    logic [63:0] subst_bytes;
    logic [3:0]  subst_len;
    logic [7:0]  hold_buf [MAX_NEEDLE];
    int          hold_cnt;

    // Output text still owed by the block, oldest beat first
    out_beat_t   replaced_q [$];
    out_beat_t   want_beat;

    int          idle_pct;
    int          stall_pct;
    int          err_cnt;
    int          sent_cnt;
    int          quiet_cycles = 0;
    logic [7:0]  alpha0;
    logic [7:0]  alpha1;

    stream_find_replace i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Check each result beat against the oldest owed beat
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (replaced_q.size() == 0) begin
                $error("unexpected result beat: out_byte %h has_byte %b string_end %b run_last %b",
                       m_data.out_byte, m_data.has_byte, m_data.string_end, m_data.run_last);
                err_cnt++;
            end else begin
                want_beat = replaced_q.pop_front();
                if (m_data.out_byte !== want_beat.out_byte) begin
                    $error("out_byte: expected %h, got %h", want_beat.out_byte, m_data.out_byte);
                    err_cnt++;
                end
                if (m_data.has_byte !== want_beat.has_byte) begin
                    $error("has_byte: expected %b, got %b", want_beat.has_byte, m_data.has_byte);
                    err_cnt++;
                end
                if (m_data.string_end !== want_beat.string_end) begin
                    $error("string_end: expected %b, got %b",
                           want_beat.string_end, m_data.string_end);
                    err_cnt++;
                end
                if (m_data.run_last !== want_beat.run_last) begin
                    $error("run_last: expected %b, got %b", want_beat.run_last, m_data.run_last);
                    err_cnt++;
                end
            end
        end
    end

    // Abort when no beat moves on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int eff_pat_len();
        int n;
        n = int'(pat_len);
        if (n < 1) n = 1;
        if (n > MAX_NEEDLE) n = MAX_NEEDLE;
        return n;
    endfunction

    function automatic int eff_subst_len();
        int n;
        n = int'(subst_len);
        if (n > MAX_SUB) n = MAX_SUB;
        return n;
    endfunction

    function automatic logic [7:0] pat_at(int i);
        return pat_bytes[8*i +: 8];
    endfunction

    function automatic logic [63:0] pack_text(string t);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < t.len() && i < 8; i++) w[8*i +: 8] = t[i];
        return w;
    endfunction

    function automatic out_beat_t text_beat(logic [7:0] b);
        out_beat_t r;
        r = '0;
        r.out_byte = b;
        r.has_byte = 1'b1;
        return r;
    endfunction

    // True when run[from +: len] equals the first len needle bytes
    function automatic bit is_pat_prefix(logic [7:0] run [MAX_NEEDLE+1], int from, int len);
        for (int i = 0; i < len; i++) begin
            if (run[from+i] != pat_at(i)) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Work out the output text caused by one accepted byte and queue it
    function automatic void replace_byte(in_beat_t beat);
        logic [7:0] run [MAX_NEEDLE+1];
        out_beat_t  res [$];
        int         n;
        int         s;
        int         nl;
        nl = eff_pat_len();
        n  = (hold_cnt > MAX_NEEDLE - 1) ? MAX_NEEDLE - 1 : hold_cnt;
        for (int i = 0; i < n; i++) run[i] = hold_buf[i];
        run[n] = beat.in_byte;
        n++;
        if (n == nl && is_pat_prefix(run, 0, n)) begin
            for (int i = 0; i < eff_subst_len(); i++) res.push_back(text_beat(subst_bytes[8*i +: 8]));
            hold_cnt = 0;
        end else begin
            // Release from the front until the rest is a proper needle prefix
            s = 0;
            while (!(n - s < nl && is_pat_prefix(run, s, n - s))) begin
                res.push_back(text_beat(run[s]));
                s++;
            end
            hold_cnt = n - s;
            for (int i = 0; i < hold_cnt; i++) hold_buf[i] = run[s+i];
        end
        if (beat.in_final) begin
            for (int i = 0; i < hold_cnt; i++) res.push_back(text_beat(hold_buf[i]));
            hold_cnt = 0;
            if (res.size() == 0) res.push_back('0);
            res[res.size()-1].string_end = 1'b1;
        end
        if (res.size() > 0) res[res.size()-1].run_last = 1'b1;
        foreach (res[i]) replaced_q.push_back(res[i]);
    endfunction

    // Drop valid and wait until every owed beat is out and the block is quiet
    task automatic wait_idle();
        s_valid = 1'b0;
        while (replaced_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_NEEDLE_BYTES: pat_bytes   = value;
            REG_NEEDLE_LEN:   pat_len     = value[3:0];
            REG_SUB_BYTES:    subst_bytes = value;
            REG_SUB_LEN:      subst_len   = value[3:0];
            default: ;
        endcase
    endtask

    task automatic load_pattern(logic [63:0] pat, logic [3:0] plen,
                                logic [63:0] sub, logic [3:0] slen);
        wait_idle();
        write_reg(REG_NEEDLE_BYTES, pat);
        write_reg(REG_NEEDLE_LEN, CFG_W'(plen));
        write_reg(REG_SUB_BYTES, sub);
        write_reg(REG_SUB_LEN, CFG_W'(slen));
    endtask

    // Send one byte beat; called and returns at a falling edge
    task automatic send_byte(logic [7:0] b, bit fin);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_data.in_byte  = b;
        s_data.in_final = fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        replace_byte(s_data);
        sent_cnt++;
        @(negedge aclk);
    endtask

    task automatic send_str(string txt, bit close);
        for (int i = 0; i < txt.len(); i++) send_byte(txt[i], close && i == txt.len() - 1);
    endtask

    // Reset registers: single zero needle, empty substitute
    task automatic test_reset_values();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_basic_replace();
        load_pattern(pack_text("ab"), 4'd2, pack_text("XYZ"), 4'd3);
        send_str("xaab", 1'b0);
        send_str("a", 1'b1);
        send_str("bab", 1'b1);
    endtask

    // Zero and oversized lengths, longest needle, deleting substitute
    task automatic test_length_limits();
        load_pattern(pack_text("q"), 4'd0, pack_text("12345678"), 4'd9);
        send_str("qq", 1'b1);
        load_pattern(pack_text("abcdefgh"), 4'd15, pack_text("Z"), 4'd0);
        send_str("abcdefgh", 1'b1);
    endtask

    // Change the needle while bytes are held
    task automatic test_reconfig_midstring();
        load_pattern(pack_text("abc"), 4'd3, pack_text("W"), 4'd1);
        send_str("ab", 1'b0);
        load_pattern(pack_text("bx"), 4'd2, pack_text("Q"), 4'd1);
        send_str("x", 1'b1);
    endtask

    task automatic random_pattern();
        logic [63:0] pat;
        logic [3:0]  plen;
        logic [3:0]  slen;
        alpha0 = 8'($urandom_range(0, 255));
        alpha1 = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0) begin
            pat    = {$urandom, $urandom};
            alpha0 = pat[7:0];
        end else begin
            // Two-letter needles overlap themselves and force partial releases
            for (int i = 0; i < 8; i++) pat[8*i +: 8] = $urandom_range(0, 1) ? alpha0 : alpha1;
        end
        case ($urandom_range(0, 5))
            0:       plen = 4'd1;
            1:       plen = 4'd8;
            2:       plen = 4'($urandom_range(0, 15));
            default: plen = 4'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 5))
            0:       slen = 4'd0;
            1:       slen = 4'd8;
            2:       slen = 4'($urandom_range(0, 15));
            default: slen = 4'($urandom_range(0, 8));
        endcase
        load_pattern(pat, plen, {$urandom, $urandom}, slen);
    endtask

    // Build a string of needle copies, broken prefixes, near letters and noise
    task automatic send_random_string();
        logic [7:0] txt [$];
        int         nl;
        int         cut;
        bit         close;
        nl = eff_pat_len();
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    for (int i = 0; i < nl; i++) txt.push_back(pat_at(i));
                end
                4, 5: begin
                    cut = $urandom_range(1, nl);
                    for (int i = 0; i < cut; i++) txt.push_back(pat_at(i));
                end
                6, 7, 8: txt.push_back($urandom_range(0, 1) ? alpha0 : alpha1);
                default: txt.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        // Leave some strings open so the next setting lands mid-string
        close = ($urandom_range(0, 5) != 0);
        foreach (txt[i]) send_byte(txt[i], close && i == txt.size() - 1);
    endtask

    task automatic test_random_streams(int idle, int stall, int items);
        int stop_at;
        idle_pct  = idle;
        stall_pct = stall;
        stop_at   = sent_cnt + items;
        while (sent_cnt < stop_at) begin
            random_pattern();
            repeat ($urandom_range(1, 3)) send_random_string();
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_NEEDLE_BYTES;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        err_cnt     = 0;
        sent_cnt    = 0;
        hold_cnt    = 0;
        pat_bytes   = '0;
        pat_len     = 4'd1;
        subst_bytes = '0;
        subst_len   = 4'd0;
        alpha0      = '0;
        alpha1      = '0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_values();
        test_basic_replace();
        test_length_limits();
        test_reconfig_midstring();
        test_random_streams(0, 0, PHASE_ITEMS);
        test_random_streams(56, 0, PHASE_ITEMS);
        test_random_streams(0, 56, PHASE_ITEMS);
        test_random_streams(38, 38, PHASE_ITEMS);

        // Flush whatever the last open string still holds
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        wait_idle();
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
